### src/double_ended_queue_unit_defines.svh
// Assertion macros shared by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Check sampled on the clock, muted while reset is held.
`define DEQ_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("deque check failed");

// Check sampled on the clock, active during reset as well.
`define DEQ_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("deque reset check failed");

`endif

### src/deq_pkg.sv
// Shared types, codes and helpers for the double-ended queue.
package deq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int KIND_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int STAT_W     = 2;
    localparam int ELEM_W     = 32;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_PUSH_FULL = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DUMPED    = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic              add_head;
        logic              add_tail;
        logic              drop_head;
        logic              drop_tail;
        logic              out_single;
        logic [STAT_W-1:0] single_status;
        logic              single_empty;
        logic              dump_start;
        logic              rd_issue;
        logic              out_from_rd;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic out_free;
        logic rd_valid;
        logic rd_last;
        logic dump_more;
    } t_stat;

    // Slot index a + b, wrapped into the store; b never exceeds DEPTH.
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                   input logic [CNT_W-1:0]  b);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - ADDR_W){1'b0}}, a} + {1'b0, b};
        if (s >= (CNT_W + 1)'(DEPTH)) begin
            s = s - (CNT_W + 1)'(DEPTH);
        end
        return s[ADDR_W-1:0];
    endfunction

endpackage

### src/deq_ctrl.sv
// Controller state machine: decodes requests and sequences the dump stream.
module deq_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [deq_pkg::KIND_W-1:0]    i_kind,
    output logic                          o_ready,
    input  deq_pkg::t_stat                i_stat,
    output deq_pkg::t_cmd                 o_cmd
);
    import deq_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = i_stat.out_free;
                if (i_valid && i_stat.out_free) begin
                    case (i_kind)
                        KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                            o_cmd.out_single = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.single_status = STAT_PUSH_FULL;
                            end else begin
                                o_cmd.single_status = STAT_DONE;
                                o_cmd.add_head      = (i_kind == KIND_PUSH_FRONT);
                                o_cmd.add_tail      = (i_kind == KIND_PUSH_BACK);
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_BACK: begin
                            o_cmd.out_single = 1'b1;
                            if (i_stat.empty) begin
                                o_cmd.single_status = STAT_POP_EMPTY;
                            end else begin
                                o_cmd.single_status = STAT_DONE;
                                o_cmd.drop_head     = (i_kind == KIND_POP_FRONT);
                                o_cmd.drop_tail     = (i_kind == KIND_POP_BACK);
                            end
                        end
                        KIND_DUMP: begin
                            if (i_stat.empty) begin
                                o_cmd.out_single    = 1'b1;
                                o_cmd.single_status = STAT_DONE;
                                o_cmd.single_empty  = 1'b1;
                            end else begin
                                o_cmd.dump_start = 1'b1;
                                n_state          = S_DUMP;
                            end
                        end
                        default: begin
                            // unknown kinds are consumed with no result
                        end
                    endcase
                end
            end
            S_DUMP: begin
                o_cmd.out_from_rd = i_stat.rd_valid && i_stat.out_free;
                o_cmd.rd_issue    = i_stat.dump_more &&
                                    (!i_stat.rd_valid || o_cmd.out_from_rd);
                if (o_cmd.out_from_rd && i_stat.rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### src/deq_datapath.sv
// Datapath: slot memory, front pointer, fill count, read stage and output register.
module deq_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [deq_pkg::VALUE_W-1:0] i_value,
    input  deq_pkg::t_cmd                 i_cmd,
    output deq_pkg::t_stat                o_stat,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [deq_pkg::STAT_W-1:0]    o_status,
    output logic signed [deq_pkg::ELEM_W-1:0] o_element,
    output logic                          o_last,
    output logic                          o_queue_empty
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    logic [ADDR_W-1:0]     r_front;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_idx;
    logic                  r_rd_valid;
    logic                  r_rd_last;
    logic [DATA_WIDTH-1:0] r_rd_data;

    logic                  r_out_valid;
    logic [STAT_W-1:0]     r_status;
    logic signed [ELEM_W-1:0] r_element;
    logic                  r_last;
    logic                  r_queue_empty;

    logic [ADDR_W-1:0]     front_dec;
    logic [ADDR_W-1:0]     front_inc;
    logic [ADDR_W-1:0]     back_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  out_load;

    // Pointer arithmetic
    always_comb begin
        front_dec = (r_front == '0) ? ADDR_W'(DEPTH - 1) : r_front - 1'b1;
        front_inc = (r_front == ADDR_W'(DEPTH - 1)) ? '0 : r_front + 1'b1;
        back_addr = wrap_add(r_front, r_count);
        rd_addr   = wrap_add(r_front, r_idx);
    end

    assign out_load = i_cmd.out_single || i_cmd.out_from_rd;

    // Status to controller
    always_comb begin
        o_stat.empty     = (r_count == '0);
        o_stat.full      = (r_count == CNT_W'(DEPTH));
        o_stat.out_free  = !r_out_valid || i_out_ready;
        o_stat.rd_valid  = r_rd_valid;
        o_stat.rd_last   = r_rd_last;
        o_stat.dump_more = (r_idx != r_count);
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_head) begin
            r_mem[front_dec] <= DATA_WIDTH'(i_value);
        end else if (i_cmd.add_tail) begin
            r_mem[back_addr] <= DATA_WIDTH'(i_value);
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Front pointer, fill count and dump read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_count    <= '0;
            r_idx      <= '0;
            r_rd_valid <= 1'b0;
            r_rd_last  <= 1'b0;
        end else begin
            if (i_cmd.add_head) begin
                r_front <= front_dec;
                r_count <= r_count + 1'b1;
            end else if (i_cmd.add_tail) begin
                r_count <= r_count + 1'b1;
            end else if (i_cmd.drop_head) begin
                r_front <= front_inc;
                r_count <= r_count - 1'b1;
            end else if (i_cmd.drop_tail) begin
                r_count <= r_count - 1'b1;
            end

            if (i_cmd.dump_start) begin
                r_idx <= '0;
            end else if (i_cmd.rd_issue) begin
                r_idx <= r_idx + 1'b1;
            end

            if (i_cmd.rd_issue) begin
                r_rd_valid <= 1'b1;
                r_rd_last  <= (r_idx + 1'b1 == r_count);
            end else if (i_cmd.out_from_rd) begin
                r_rd_valid <= 1'b0;
            end
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_from_rd) begin
            r_status      <= STAT_DUMPED;
            r_element     <= ELEM_W'(signed'(r_rd_data));
            r_last        <= r_rd_last;
            r_queue_empty <= 1'b0;
        end else if (i_cmd.out_single) begin
            r_status      <= i_cmd.single_status;
            r_element     <= '0;
            r_last        <= 1'b1;
            r_queue_empty <= i_cmd.single_empty;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_element     = r_element;
    assign o_last        = r_last;
    assign o_queue_empty = r_queue_empty;

endmodule

### src/double_ended_queue_unit.sv
// Top level of the double-ended queue: controller plus datapath.
//
// Usage:
//   Requests enter on the s_axis channel: s_axis_tuser carries the command
//   kind (push front, push back, pop front, pop back, dump), s_axis_tdata the
//   value to push. Results leave on m_axis: status and the empty marker in
//   m_axis_tuser, the dumped element in m_axis_tdata, m_axis_tlast on the
//   final result of each request.
//   Push and pop: one result, registered in the cycle after the request is
//   taken; a new request every cycle while the result side keeps up.
//   Dump of N elements: N results through the single registered read port of
//   the slot memory and the output register, one per cycle while not stalled.
//   No request is taken until the final element has moved to the output.
//   Unknown kinds are consumed and produce no result.
//   Reset empties the queue (front pointer and count cleared) and drops any
//   pending result; slot contents are not cleared.
//   When m_axis_tready is low a pending result holds and s_axis_tready
//   drops; a dump pauses its reads until the output frees up.
module double_ended_queue_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] value
    input  logic [2:0]  s_axis_tuser,  // [2:0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [31:0] element
    output logic [2:0]  m_axis_tuser,  // [1:0] status, [2] queue_empty
    output logic        m_axis_tlast
);
    import deq_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic [STAT_W-1:0] status;
    logic signed [ELEM_W-1:0] element;
    logic              last;
    logic              queue_empty;

    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_kind  (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    deq_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value       (signed'(s_axis_tdata)),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (status),
        .o_element     (element),
        .o_last        (last),
        .o_queue_empty (queue_empty)
    );

    assign m_axis_tdata = element;
    assign m_axis_tuser = {queue_empty, status};
    assign m_axis_tlast = last;

endmodule

### src/deq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level.
`include "double_ended_queue_unit_defines.svh"

module deq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import deq_pkg::*;

    // A stalled result holds its payload
    `DEQ_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

    // Reset drops any pending result
    `DEQ_ASSERT_RST(a_reset_clears, !i_rst_n |=> !m_axis_tvalid)

    // Push, pop and empty-dump results are single and carry no element
    `DEQ_ASSERT(a_single_result, m_axis_tvalid && m_axis_tuser[1:0] != STAT_DUMPED |-> m_axis_tlast && m_axis_tdata == '0)

    // The empty marker only comes with a plain done status
    `DEQ_ASSERT(a_empty_marker, m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == STAT_DONE)

    // No request is taken while a dump stream is still unfinished
    `DEQ_ASSERT(a_dump_blocks, m_axis_tvalid && m_axis_tuser[1:0] == STAT_DUMPED && !m_axis_tlast |-> !s_axis_tready)

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (.*);
